[sv/ytpid_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ytpid_pkg
// Shared types, codes and helpers of the yaw turn PID controller.
// ----------------------------------------------------------------------------
package ytpid_pkg;

  // result status codes
  localparam logic [2:0] ST_RUNNING  = 3'd0;
  localparam logic [2:0] ST_REACHED  = 3'd1;
  localparam logic [2:0] ST_STOP     = 3'd2;
  localparam logic [2:0] ST_SENSOR   = 3'd3;
  localparam logic [2:0] ST_TIMEOUT  = 3'd4;
  localparam logic [2:0] ST_IDLE     = 3'd5;

  // command codes
  localparam logic CMD_START  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // configuration register indexes
  localparam logic [2:0] REG_TURN_DELTA    = 3'd0;
  localparam logic [2:0] REG_RATE_LIMIT    = 3'd1;
  localparam logic [2:0] REG_ANGLE_TOL     = 3'd2;
  localparam logic [2:0] REG_TIMEOUT       = 3'd3;
  localparam logic [2:0] REG_GAIN_P        = 3'd4;
  localparam logic [2:0] REG_GAIN_I        = 3'd5;
  localparam logic [2:0] REG_GAIN_D        = 3'd6;
  localparam logic [2:0] REG_STABLE_NEEDED = 3'd7;

  localparam int CFG_W      = 17;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 24;

  localparam logic signed [32:0] INTEGRAL_LIMIT = 33'sd8000000;
  localparam logic signed [26:0] MICRO_SCALE    = 27'sd1000000;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_MUL_E, S_INTEG, S_MUL_P, S_MUL_PT, S_MUL_I,
    S_MUL_IT, S_MUL_D, S_MUL_DT, S_SUM, S_DIV, S_CLAMP, S_FINISH
  } ytpid_state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_DECODE, OP_MUL_E, OP_INTEG, OP_MUL_P, OP_MUL_PT,
    OP_MUL_I, OP_MUL_IT, OP_MUL_D, OP_MUL_DT, OP_SUM, OP_DIV, OP_CLAMP
  } ytpid_op_t;

  typedef struct packed {
    ytpid_op_t op;
    logic      out_load;
  } ytpid_ctrl_t;

  typedef struct packed {
    logic quick;
    logic reached;
    logic div_last;
    logic out_free;
  } ytpid_stat_t;

  // wrap an angle sum into +-18000 centidegrees (at most three full turns off)
  function automatic logic signed [15:0] wrap_angle(input logic signed [18:0] v);
    logic signed [18:0] r;
    begin
      if (v > 19'sd90000) r = v - 19'sd108000;
      else if (v > 19'sd54000) r = v - 19'sd72000;
      else if (v > 19'sd18000) r = v - 19'sd36000;
      else if (v < -19'sd90000) r = v + 19'sd108000;
      else if (v < -19'sd54000) r = v + 19'sd72000;
      else if (v < -19'sd18000) r = v + 19'sd36000;
      else r = v;
      wrap_angle = r[15:0];
    end
  endfunction

endpackage

[sv/yaw_turn_pid_controller.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yaw_turn_pid_controller
// PID heading controller with angle wrap, clamped integral and rate limit.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_ channel; tuser selects start (0) or sample (1).
//   Every request yields exactly one result on the m_ channel: a Q8.8 turn
//   rate and a status code. Registers are written through cfg_we, cfg_index
//   and cfg_data while no request is in flight.
// Timing:
//   One request is worked at a time. A start, an idle sample or a sample
//   that ends the turn by timeout, stop or sensor fault goes from decode
//   to finish; a sample that reaches the angle adds the error product and
//   integral step. A running sample steps one shared multiplier through
//   seven products and a restoring divider through 64 quotient bits. The
//   next request is accepted in the cycle after a result is loaded.
// Reset:
//   rst clears the turn state and restores register defaults; the block is
//   idle and the output channel empty afterward.
// Stall:
//   A result waits in the output register while m_tready is low; the next
//   request is accepted meanwhile and its result is held until the register
//   frees.
// ----------------------------------------------------------------------------
module yaw_turn_pid_controller (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [2:0]                       cfg_index,
  input  logic [ytpid_pkg::CFG_W-1:0]      cfg_data,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // yaw_angle[15:0], yaw_valid[16], stop_request[17], time_now_ms[49:18]
  input  logic [ytpid_pkg::IN_DATA_W-1:0]  s_tdata,
  // cmd[0]
  input  logic                             s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // rate_command[15:0], status[18:16]
  output logic [ytpid_pkg::OUT_DATA_W-1:0] m_tdata
);

  ytpid_pkg::ytpid_ctrl_t ctrl;
  ytpid_pkg::ytpid_stat_t stat;

  ytpid_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  ytpid_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .ctrl      (ctrl),
    .stat      (stat)
  );

endmodule

[sv/ytpid_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ytpid_ctrl
// Sequencer: walks one request through decode, multiply steps and divide, or finishes early.
// ----------------------------------------------------------------------------
module ytpid_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  ytpid_pkg::ytpid_stat_t stat,
  output ytpid_pkg::ytpid_ctrl_t ctrl
);

  ytpid_pkg::ytpid_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ytpid_pkg::S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next    = state;
    ctrl.op       = ytpid_pkg::OP_NONE;
    ctrl.out_load = 1'b0;
    s_tready      = 1'b0;
    case (state)
      ytpid_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          ctrl.op    = ytpid_pkg::OP_LOAD;
          state_next = ytpid_pkg::S_DECODE;
        end
      end
      ytpid_pkg::S_DECODE: begin
        ctrl.op    = ytpid_pkg::OP_DECODE;
        state_next = stat.quick ? ytpid_pkg::S_FINISH : ytpid_pkg::S_MUL_E;
      end
      ytpid_pkg::S_MUL_E: begin
        ctrl.op    = ytpid_pkg::OP_MUL_E;
        state_next = ytpid_pkg::S_INTEG;
      end
      ytpid_pkg::S_INTEG: begin
        ctrl.op    = ytpid_pkg::OP_INTEG;
        state_next = stat.reached ? ytpid_pkg::S_FINISH : ytpid_pkg::S_MUL_P;
      end
      ytpid_pkg::S_MUL_P: begin
        ctrl.op    = ytpid_pkg::OP_MUL_P;
        state_next = ytpid_pkg::S_MUL_PT;
      end
      ytpid_pkg::S_MUL_PT: begin
        ctrl.op    = ytpid_pkg::OP_MUL_PT;
        state_next = ytpid_pkg::S_MUL_I;
      end
      ytpid_pkg::S_MUL_I: begin
        ctrl.op    = ytpid_pkg::OP_MUL_I;
        state_next = ytpid_pkg::S_MUL_IT;
      end
      ytpid_pkg::S_MUL_IT: begin
        ctrl.op    = ytpid_pkg::OP_MUL_IT;
        state_next = ytpid_pkg::S_MUL_D;
      end
      ytpid_pkg::S_MUL_D: begin
        ctrl.op    = ytpid_pkg::OP_MUL_D;
        state_next = ytpid_pkg::S_MUL_DT;
      end
      ytpid_pkg::S_MUL_DT: begin
        ctrl.op    = ytpid_pkg::OP_MUL_DT;
        state_next = ytpid_pkg::S_SUM;
      end
      ytpid_pkg::S_SUM: begin
        ctrl.op    = ytpid_pkg::OP_SUM;
        state_next = ytpid_pkg::S_DIV;
      end
      ytpid_pkg::S_DIV: begin
        ctrl.op = ytpid_pkg::OP_DIV;
        if (stat.div_last) state_next = ytpid_pkg::S_CLAMP;
      end
      ytpid_pkg::S_CLAMP: begin
        ctrl.op    = ytpid_pkg::OP_CLAMP;
        state_next = ytpid_pkg::S_FINISH;
      end
      ytpid_pkg::S_FINISH: begin
        // hold until the output register is free
        if (stat.out_free) begin
          ctrl.out_load = 1'b1;
          state_next    = ytpid_pkg::S_IDLE;
        end
      end
      default: state_next = ytpid_pkg::S_IDLE;
    endcase
  end

endmodule

[sv/ytpid_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ytpid_datapath
// Registers, turn state, shared multiplier, restoring divider, output register.
// ----------------------------------------------------------------------------
module ytpid_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [2:0]                       cfg_index,
  input  logic [ytpid_pkg::CFG_W-1:0]      cfg_data,
  input  logic [ytpid_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic                             s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [ytpid_pkg::OUT_DATA_W-1:0] m_tdata,
  input  ytpid_pkg::ytpid_ctrl_t           ctrl,
  output ytpid_pkg::ytpid_stat_t           stat
);

  // configuration
  logic signed [16:0] turn_delta;
  logic [14:0]        rate_limit;
  logic [14:0]        angle_tolerance;
  logic [15:0]        timeout_limit_ms;
  logic signed [15:0] gain_p, gain_i, gain_d;
  logic [7:0]         stable_needed;

  // latched request
  logic               cmd_r, yaw_valid_r, stop_r;
  logic signed [15:0] yaw_r;
  logic [31:0]        now_r;

  // turn state
  logic               turn_active;
  logic signed [15:0] target_angle;
  logic signed [23:0] error_integral;
  logic signed [15:0] previous_error;
  logic [7:0]         stable_run;
  logic [31:0]        start_time, previous_time;

  // working registers
  logic signed [15:0] err_r;
  logic [15:0]        dt_r;
  logic [25:0]        div_r;
  logic signed [16:0] derr_r;
  logic signed [63:0] prod, acc;
  logic [63:0]        quo;
  logic [25:0]        rem;
  logic               neg_r;
  logic [5:0]         cnt;
  logic signed [15:0] res_rate, m_rate;
  logic [2:0]         res_status, m_status;

  // decode logic
  logic signed [15:0] start_target, start_err, samp_err;
  logic [31:0]        elapsed, dt_raw;
  logic               timed_out;
  logic [15:0]        dt_sat;

  always_comb begin
    start_target = ytpid_pkg::wrap_angle({{3{yaw_r[15]}}, yaw_r}
                                         + {{2{turn_delta[16]}}, turn_delta});
    start_err = ytpid_pkg::wrap_angle({{3{start_target[15]}}, start_target}
                                      - {{3{yaw_r[15]}}, yaw_r});
    samp_err = ytpid_pkg::wrap_angle({{3{target_angle[15]}}, target_angle}
                                     - {{3{yaw_r[15]}}, yaw_r});
    elapsed   = now_r - start_time;
    timed_out = elapsed >= {16'd0, timeout_limit_ms};
    dt_raw    = now_r - previous_time;
    if (dt_raw == 32'd0) dt_sat = 16'd1;
    else if (dt_raw > 32'd65535) dt_sat = 16'hFFFF;
    else dt_sat = dt_raw[15:0];
  end

  assign stat.quick = (cmd_r == ytpid_pkg::CMD_START) || !turn_active || timed_out
                      || stop_r || !yaw_valid_r;

  // shared multiplier
  logic signed [40:0] mul_a;
  logic signed [26:0] mul_b;
  logic signed [67:0] mul_p;

  always_comb begin
    mul_a = {{25{err_r[15]}}, err_r};
    mul_b = {11'd0, dt_r};
    case (ctrl.op)
      ytpid_pkg::OP_MUL_E: begin
        mul_a = {{25{err_r[15]}}, err_r};
        mul_b = {11'd0, dt_r};
      end
      ytpid_pkg::OP_MUL_P: begin
        mul_a = {{25{err_r[15]}}, err_r};
        mul_b = {{11{gain_p[15]}}, gain_p};
      end
      ytpid_pkg::OP_MUL_PT: begin
        mul_a = {{9{prod[31]}}, prod[31:0]};
        mul_b = {1'b0, div_r};
      end
      ytpid_pkg::OP_MUL_I: begin
        mul_a = {{17{error_integral[23]}}, error_integral};
        mul_b = {{11{gain_i[15]}}, gain_i};
      end
      ytpid_pkg::OP_MUL_IT: begin
        mul_a = prod[40:0];
        mul_b = {11'd0, dt_r};
      end
      ytpid_pkg::OP_MUL_D: begin
        mul_a = {{24{derr_r[16]}}, derr_r};
        mul_b = {{11{gain_d[15]}}, gain_d};
      end
      ytpid_pkg::OP_MUL_DT: begin
        mul_a = prod[40:0];
        mul_b = ytpid_pkg::MICRO_SCALE;
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // integral clamp, tolerance band and stability run
  logic signed [32:0] isum;
  logic signed [23:0] integ_next;
  logic [15:0]        abs_err;
  logic               in_band;
  logic [7:0]         run_inc;

  always_comb begin
    isum = {{9{error_integral[23]}}, error_integral} + prod[32:0];
    if (isum > ytpid_pkg::INTEGRAL_LIMIT) integ_next = 24'sd8000000;
    else if (isum < -ytpid_pkg::INTEGRAL_LIMIT) integ_next = -24'sd8000000;
    else integ_next = isum[23:0];
    abs_err = err_r[15] ? 16'(-err_r) : err_r;
    in_band = abs_err <= {1'b0, angle_tolerance};
    run_inc = (stable_run < 8'd255) ? stable_run + 8'd1 : stable_run;
  end

  assign stat.reached = in_band && (run_inc >= stable_needed);

  // sum and divide
  logic signed [63:0] sum;
  logic [26:0]        rem_s;
  logic [14:0]        mag;
  logic [15:0]        mag_ext;

  always_comb begin
    sum     = acc + prod;
    rem_s   = {rem, quo[63]};
    mag     = (quo > {49'd0, rate_limit}) ? rate_limit : quo[14:0];
    mag_ext = {1'b0, mag};
  end

  assign stat.div_last = (cnt == 6'd63);
  assign stat.out_free = !m_tvalid || m_tready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      turn_delta       <= '0;
      rate_limit       <= 15'd256;
      angle_tolerance  <= 15'd200;
      timeout_limit_ms <= 16'd5000;
      gain_p           <= '0;
      gain_i           <= '0;
      gain_d           <= '0;
      stable_needed    <= 8'd5;
    end else if (cfg_we) begin
      case (cfg_index)
        ytpid_pkg::REG_TURN_DELTA:    turn_delta       <= cfg_data;
        ytpid_pkg::REG_RATE_LIMIT:    rate_limit       <= cfg_data[14:0];
        ytpid_pkg::REG_ANGLE_TOL:     angle_tolerance  <= cfg_data[14:0];
        ytpid_pkg::REG_TIMEOUT:       timeout_limit_ms <= cfg_data[15:0];
        ytpid_pkg::REG_GAIN_P:        gain_p           <= cfg_data[15:0];
        ytpid_pkg::REG_GAIN_I:        gain_i           <= cfg_data[15:0];
        ytpid_pkg::REG_GAIN_D:        gain_d           <= cfg_data[15:0];
        ytpid_pkg::REG_STABLE_NEEDED: stable_needed    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // turn state
  always_ff @(posedge clk) begin
    if (rst) begin
      turn_active    <= 1'b0;
      target_angle   <= '0;
      error_integral <= '0;
      previous_error <= '0;
      stable_run     <= '0;
      start_time     <= '0;
      previous_time  <= '0;
    end else begin
      case (ctrl.op)
        ytpid_pkg::OP_DECODE: begin
          if (cmd_r == ytpid_pkg::CMD_START) begin
            if (!yaw_valid_r) begin
              turn_active <= 1'b0;
            end else begin
              target_angle   <= start_target;
              error_integral <= '0;
              previous_error <= start_err;
              stable_run     <= '0;
              start_time     <= now_r;
              previous_time  <= now_r;
              turn_active    <= 1'b1;
            end
          end else if (turn_active) begin
            if (timed_out || stop_r || !yaw_valid_r) turn_active <= 1'b0;
            else previous_time <= now_r;
          end
        end
        ytpid_pkg::OP_INTEG: begin
          error_integral <= integ_next;
          previous_error <= err_r;
          stable_run     <= in_band ? run_inc : 8'd0;
          if (stat.reached) turn_active <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // request latch and working registers
  always_ff @(posedge clk) begin
    case (ctrl.op)
      ytpid_pkg::OP_LOAD: begin
        yaw_r       <= s_tdata[15:0];
        yaw_valid_r <= s_tdata[16];
        stop_r      <= s_tdata[17];
        now_r       <= s_tdata[49:18];
        cmd_r       <= s_tuser;
      end
      ytpid_pkg::OP_DECODE: begin
        err_r    <= samp_err;
        dt_r     <= dt_sat;
        div_r    <= {dt_sat, 10'd0} - {6'd0, dt_sat, 4'd0} - {7'd0, dt_sat, 3'd0};
        res_rate <= '0;
        if (cmd_r == ytpid_pkg::CMD_START) res_status <= yaw_valid_r ?
                                            ytpid_pkg::ST_RUNNING : ytpid_pkg::ST_SENSOR;
        else if (!turn_active) res_status <= ytpid_pkg::ST_IDLE;
        else if (timed_out) res_status <= ytpid_pkg::ST_TIMEOUT;
        else if (stop_r) res_status <= ytpid_pkg::ST_STOP;
        else res_status <= ytpid_pkg::ST_SENSOR;
      end
      ytpid_pkg::OP_MUL_E, ytpid_pkg::OP_MUL_P, ytpid_pkg::OP_MUL_PT,
      ytpid_pkg::OP_MUL_IT, ytpid_pkg::OP_MUL_DT: begin
        prod <= mul_p[63:0];
      end
      ytpid_pkg::OP_INTEG: begin
        derr_r     <= {err_r[15], err_r} - {previous_error[15], previous_error};
        res_rate   <= '0;
        res_status <= ytpid_pkg::ST_REACHED;
      end
      ytpid_pkg::OP_MUL_I: begin
        acc  <= prod;
        prod <= mul_p[63:0];
      end
      ytpid_pkg::OP_MUL_D: begin
        acc  <= acc + prod;
        prod <= mul_p[63:0];
      end
      ytpid_pkg::OP_SUM: begin
        neg_r <= sum[63];
        quo   <= sum[63] ? 64'(-sum) : sum;
        rem   <= '0;
        cnt   <= '0;
      end
      ytpid_pkg::OP_DIV: begin
        cnt <= cnt + 6'd1;
        if (rem_s >= {1'b0, div_r}) begin
          rem <= 26'(rem_s - {1'b0, div_r});
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= rem_s[25:0];
          quo <= {quo[62:0], 1'b0};
        end
      end
      ytpid_pkg::OP_CLAMP: begin
        res_rate   <= neg_r ? 16'(-mag_ext) : mag_ext;
        res_status <= ytpid_pkg::ST_RUNNING;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (ctrl.out_load) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      m_rate   <= res_rate;
      m_status <= res_status;
    end
  end

  assign m_tdata = {5'd0, m_status, m_rate};

endmodule
